// ===== rtl/pngpu_pkg.sv =====
// ----------------------------------------------------------------------------
// pngpu_pkg
// Shared widths, filter codes and the Paeth predictor for the PNG row filter
// reconstruction unit.
// ----------------------------------------------------------------------------
package pngpu_pkg;

	localparam int MAX_COLUMNS = 1024;
	localparam int ADDR_W      = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
	localparam int COL_W       = 11;
	localparam int BYTE_W      = 8;
	localparam int PADDR_W     = 3;
	localparam int PDATA_W     = 32;

	localparam logic [PADDR_W-1:0] REG_ROW_COLUMNS = '0;
	localparam logic [COL_W-1:0]   ROW_COLUMNS_RST = COL_W'(1);

	localparam logic [BYTE_W-1:0] FILT_NONE  = 8'd0;
	localparam logic [BYTE_W-1:0] FILT_SUB   = 8'd1;
	localparam logic [BYTE_W-1:0] FILT_UP    = 8'd2;
	localparam logic [BYTE_W-1:0] FILT_AVG   = 8'd3;
	localparam logic [BYTE_W-1:0] FILT_PAETH = 8'd4;

	typedef logic [BYTE_W-1:0] byte_t;

	// Paeth picks whichever of left, up and upper-left lies nearest to
	// left + up - upper_left; ties favour left, then up.
	function automatic byte_t paeth_pick(input byte_t a, input byte_t b, input byte_t c);
		logic [BYTE_W-1:0] pa;
		logic [BYTE_W-1:0] pb;
		logic [BYTE_W+1:0] sum_ab;
		logic [BYTE_W+1:0] two_c;
		logic [BYTE_W+1:0] pc;
		pa     = (b > c) ? (b - c) : (c - b);
		pb     = (a > c) ? (a - c) : (c - a);
		sum_ab = (BYTE_W+2)'(a) + (BYTE_W+2)'(b);
		two_c  = (BYTE_W+2)'(c) + (BYTE_W+2)'(c);
		pc     = (sum_ab > two_c) ? (sum_ab - two_c) : (two_c - sum_ab);
		if (((BYTE_W+2)'(pa) <= (BYTE_W+2)'(pb)) && ((BYTE_W+2)'(pa) <= pc)) begin
			return a;
		end else if ((BYTE_W+2)'(pb) <= pc) begin
			return b;
		end else begin
			return c;
		end
	endfunction

endpackage

// ===== rtl/pngpu_if.sv =====
// ----------------------------------------------------------------------------
// pngpu_if
// Request channels of the PNG row filter reconstruction unit: the stream
// input and the reconstructed byte output.
// ----------------------------------------------------------------------------
interface pngpu_in_if import pngpu_pkg::*; ();
	logic  valid;
	logic  ready;
	byte_t stream_byte;
	logic  end_of_stream;

	modport source (output valid, output stream_byte, output end_of_stream, input ready);
	modport sink   (input valid, input stream_byte, input end_of_stream, output ready);
endinterface

interface pngpu_out_if import pngpu_pkg::*; ();
	logic  valid;
	logic  ready;
	byte_t decoded_byte;
	logic  byte_valid;
	logic  row_last;
	logic  stream_last;
	logic  length_error;

	modport source (output valid, output decoded_byte, output byte_valid, output row_last,
		output stream_last, output length_error, input ready);
	modport sink   (input valid, input decoded_byte, input byte_valid, input row_last,
		input stream_last, input length_error, output ready);
endinterface

// ===== rtl/png_predictor_undo_unit.sv =====
// ----------------------------------------------------------------------------
// png_predictor_undo_unit
// Reconstructs PNG row filters (None, Sub, Up, Average, Paeth) on an inflated
// stream of one byte per pixel, keeping the previous row in a RAM.
// ----------------------------------------------------------------------------
//  channel  | dir | contents
//  in_chan  | in  | stream_byte, end_of_stream
//  out_chan | out | decoded_byte, byte_valid, row_last, stream_last, length_error
//  apb      | in  | row_columns at byte address 0
//
// One request is taken per cycle unless stage 1 is held by a stalled output;
// each is registered in stage 1 with its read of the prior-row RAM, and each
// data byte or end-of-stream marker then passes to the stage 2 output register.
// The RAM is read at acceptance and written back when the byte leaves stage 1.
// Reset clears all control state; the RAM is not cleared, as every entry is
// written by the first row before a read of it is used.
// A stalled output holds stage 1 and, through it, the input.
// ----------------------------------------------------------------------------
module png_predictor_undo_unit
	import pngpu_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	pngpu_in_if.sink           in_chan,
	pngpu_out_if.source        out_chan,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready
);

	typedef struct packed {
		byte_t             in_byte;
		logic              is_data;
		logic              eos;
		logic              row_end;
		logic              first_row;
		logic [ADDR_W-1:0] addr;
	} stage_t;

	// Prior-row RAM
	byte_t prior_mem [MAX_COLUMNS];

	// Configuration
	logic [COL_W-1:0] row_columns_q;
	logic [COL_W-1:0] cols_eff;

	// Front-end state
	logic [COL_W-1:0] row_pos_q;
	logic             first_row_q;
	logic [COL_W-1:0] pos_m1;
	logic             in_fire;
	logic             in_is_data;
	logic             in_row_end;

	// Stage 1
	logic   valid_s1;
	stage_t ctl_s1;
	byte_t  prior_s1;
	logic   s1_adv;
	logic   s1_move;
	byte_t  up_b;
	byte_t  val;

	// Reconstruction state
	byte_t filt_q;
	byte_t left_q;
	byte_t upleft_q;

	// Stage 2 (output register)
	logic  valid_s2;
	byte_t decoded_s2;
	logic  byte_valid_s2;
	logic  row_last_s2;
	logic  stream_last_s2;
	logic  length_error_s2;

	// ---------------- configuration port ----------------
	assign pready = 1'b1;
	assign prdata = PDATA_W'(row_columns_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_columns_q <= ROW_COLUMNS_RST;
		end else if (psel && penable && pwrite && pready && (paddr == REG_ROW_COLUMNS)) begin
			row_columns_q <= pwdata[COL_W-1:0];
		end
	end

	always_comb begin
		cols_eff = row_columns_q;
		if (row_columns_q == '0) begin
			cols_eff = COL_W'(1);
		end else if (row_columns_q > COL_W'(MAX_COLUMNS)) begin
			cols_eff = COL_W'(MAX_COLUMNS);
		end
	end

	// ---------------- front end: row position and RAM read ----------------
	assign s1_adv        = !valid_s2 || out_chan.ready;
	assign s1_move       = valid_s1 && s1_adv;
	assign in_chan.ready = !valid_s1 || s1_adv;
	assign in_fire       = in_chan.valid && in_chan.ready;
	assign in_is_data    = (row_pos_q != '0);
	assign in_row_end    = in_is_data && (row_pos_q >= cols_eff);
	assign pos_m1        = row_pos_q - COL_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_pos_q   <= '0;
			first_row_q <= 1'b1;
		end else if (in_fire) begin
			if (in_chan.end_of_stream) begin
				row_pos_q   <= '0;
				first_row_q <= 1'b1;
			end else if (!in_is_data) begin
				row_pos_q <= COL_W'(1);
			end else if (in_row_end) begin
				row_pos_q   <= '0;
				first_row_q <= 1'b0;
			end else begin
				row_pos_q <= row_pos_q + COL_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_fire) begin
			valid_s1 <= 1'b1;
		end else if (s1_move) begin
			valid_s1 <= 1'b0;
		end
	end

	// The write of a column always leaves stage 1 before the next row's read
	// of that column is accepted, as a filter byte lies between them.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			ctl_s1.in_byte   <= in_chan.stream_byte;
			ctl_s1.is_data   <= in_is_data;
			ctl_s1.eos       <= in_chan.end_of_stream;
			ctl_s1.row_end   <= in_row_end;
			ctl_s1.first_row <= first_row_q;
			ctl_s1.addr      <= ADDR_W'(pos_m1);
			prior_s1         <= prior_mem[ADDR_W'(pos_m1)];
		end
		if (s1_move && ctl_s1.is_data) begin
			prior_mem[ctl_s1.addr] <= val;
		end
	end

	// ---------------- stage 1: reconstruction ----------------
	assign up_b = ctl_s1.first_row ? '0 : prior_s1;

	always_comb begin
		logic [BYTE_W:0] avg_sum;
		avg_sum = (BYTE_W+1)'(left_q) + (BYTE_W+1)'(up_b);
		case (filt_q)
			FILT_SUB:   val = ctl_s1.in_byte + left_q;
			FILT_UP:    val = ctl_s1.in_byte + up_b;
			FILT_AVG:   val = ctl_s1.in_byte + avg_sum[BYTE_W:1];
			FILT_PAETH: val = ctl_s1.in_byte + paeth_pick(left_q, up_b, upleft_q);
			default:    val = ctl_s1.in_byte;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filt_q   <= FILT_NONE;
			left_q   <= '0;
			upleft_q <= '0;
		end else if (s1_move) begin
			if (ctl_s1.eos) begin
				filt_q   <= FILT_NONE;
				left_q   <= '0;
				upleft_q <= '0;
			end else if (!ctl_s1.is_data) begin
				filt_q   <= ctl_s1.in_byte;
				left_q   <= '0;
				upleft_q <= '0;
			end else begin
				left_q   <= val;
				upleft_q <= up_b;
			end
		end
	end

	// ---------------- stage 2: output register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s1_move) begin
			valid_s2 <= ctl_s1.is_data || ctl_s1.eos;
		end else if (out_chan.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move) begin
			decoded_s2      <= ctl_s1.is_data ? val : '0;
			byte_valid_s2   <= ctl_s1.is_data;
			row_last_s2     <= ctl_s1.row_end;
			stream_last_s2  <= ctl_s1.eos;
			length_error_s2 <= ctl_s1.eos && !ctl_s1.row_end;
		end
	end

	assign out_chan.valid        = valid_s2;
	assign out_chan.decoded_byte = decoded_s2;
	assign out_chan.byte_valid   = byte_valid_s2;
	assign out_chan.row_last     = row_last_s2;
	assign out_chan.stream_last  = stream_last_s2;
	assign out_chan.length_error = length_error_s2;

	// ---------------- assertions ----------------
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		row_pos_q <= COL_W'(MAX_COLUMNS))
		else $error("row position beyond the RAM depth");

	a_eos_restart: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && in_chan.end_of_stream |=> (row_pos_q == '0) && first_row_q)
		else $error("end of stream did not restart the row state");

	a_error_only: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !byte_valid_s2 |-> stream_last_s2 && length_error_s2 && !row_last_s2)
		else $error("result without a data byte that is not a length error");

	a_error_last: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && length_error_s2 |-> stream_last_s2)
		else $error("length error raised before the end of the stream");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !s1_adv |=> valid_s1 && $stable(ctl_s1))
		else $error("stage 1 changed while the output was stalled");

endmodule
